// ===== rtl/core/bemf_speed_pi_hbridge_drive_macros.svh =====
// Assertion macros used by the drive top level.
`ifndef BEMF_SPEED_PI_HBRIDGE_DRIVE_MACROS_SVH
`define BEMF_SPEED_PI_HBRIDGE_DRIVE_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BSPHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// next-cycle implication
`define BSPHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsphd_pkg.sv =====
// Shared constants, types and codes for the back-EMF PI H-bridge drive.
package bsphd_pkg;

  localparam int unsigned REG_W     = 31;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned PWM_W     = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PARAM_W   = 16;

  localparam int unsigned PWM_PERIOD_DEF        = 4095;
  localparam int unsigned SAMPLE_FULL_SCALE_DEF = 4095;

  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 31;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_STEPS = MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_STEPS = DIV_Q_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] HELP_RST = 31'd65536;
  localparam logic [REG_W-1:0] OMAX_RST = 31'd65536;

  localparam logic [DUTY_W-1:0] DUTY_ONE = 16'h8000;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 16'h7FFF;

  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_GAIN,
    CFG_HELP_FACTOR,
    CFG_WINDING_RES,
    CFG_SPEED_CONST,
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_ERR_DEADBAND,
    CFG_OUTPUT_MAX
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] current_gain;
    logic [REG_W-1:0] help_factor;
    logic [REG_W-1:0] winding_resistance;
    logic [REG_W-1:0] speed_constant;
    logic [REG_W-1:0] prop_gain;
    logic [REG_W-1:0] integ_step_gain;
    logic [REG_W-1:0] error_deadband;
    logic [REG_W-1:0] output_max;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [REG_W-1:0] num;
    logic [REG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CUR_GO,
    ST_CUR_WT,
    ST_IR_GO,
    ST_IR_WT,
    ST_SPD_GO,
    ST_SPD_WT,
    ST_ERR,
    ST_DBD,
    ST_INT_GO,
    ST_INT_WT,
    ST_PRP_GO,
    ST_PRP_WT,
    ST_LIM,
    ST_DIV_GO,
    ST_DIV_WT,
    ST_HLP_GO,
    ST_HLP_WT,
    ST_PWM_GO,
    ST_PWM_WT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/bsphd_if.sv =====
// Input and result channel interfaces (valid/ready handshake).
interface bsphd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [bsphd_pkg::SAMPLE_W-1:0]         filtered_sample;
  logic signed [bsphd_pkg::SPEED_W-1:0]   target_speed;

  modport source (output valid, output filtered_sample, output target_speed, input ready);
  modport sink   (input valid, input filtered_sample, input target_speed, output ready);
endinterface

interface bsphd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [bsphd_pkg::PWM_W-1:0]            pwm_compare;
  logic [bsphd_pkg::DIR_W-1:0]            drive_direction;
  logic                                   dead_time_pause;
  logic signed [bsphd_pkg::SPEED_W-1:0]   speed_estimate;
  logic [bsphd_pkg::REG_W-1:0]            motor_current;

  modport source (output valid, output pwm_compare, output drive_direction,
                  output dead_time_pause, output speed_estimate, output motor_current,
                  input ready);
  modport sink   (input valid, input pwm_compare, input drive_direction,
                  input dead_time_pause, input speed_estimate, input motor_current,
                  output ready);
endinterface

// ===== rtl/core/bsphd_cfg_regs.sv =====
// Configuration register file with write decode and reset defaults.
module bsphd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [bsphd_pkg::CFG_IDX_W-1:0]  index,
  input  logic [bsphd_pkg::REG_W-1:0]      wdata,
  output bsphd_pkg::cfg_t                  cfg
);

  bsphd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_gain       <= '0;
      cfg_r.help_factor        <= bsphd_pkg::HELP_RST;
      cfg_r.winding_resistance <= '0;
      cfg_r.speed_constant     <= '0;
      cfg_r.prop_gain          <= '0;
      cfg_r.integ_step_gain    <= '0;
      cfg_r.error_deadband     <= '0;
      cfg_r.output_max         <= bsphd_pkg::OMAX_RST;
    end else if (we) begin
      case (bsphd_pkg::cfg_idx_t'(index))
        bsphd_pkg::CFG_CURRENT_GAIN: cfg_r.current_gain       <= wdata;
        bsphd_pkg::CFG_HELP_FACTOR:  cfg_r.help_factor        <= wdata;
        bsphd_pkg::CFG_WINDING_RES:  cfg_r.winding_resistance <= wdata;
        bsphd_pkg::CFG_SPEED_CONST:  cfg_r.speed_constant     <= wdata;
        bsphd_pkg::CFG_PROP_GAIN:    cfg_r.prop_gain          <= wdata;
        bsphd_pkg::CFG_INTEG_GAIN:   cfg_r.integ_step_gain    <= wdata;
        bsphd_pkg::CFG_ERR_DEADBAND: cfg_r.error_deadband     <= wdata;
        bsphd_pkg::CFG_OUTPUT_MAX:   cfg_r.output_max         <= wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/bsphd_ser_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module bsphd_ser_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsphd_pkg::mul_req_t  req,
  output bsphd_pkg::mul_rsp_t  rsp
);

  localparam int unsigned AW = bsphd_pkg::MUL_A_W;
  localparam int unsigned BW = bsphd_pkg::MUL_B_W;
  localparam int unsigned PW = bsphd_pkg::MUL_P_W;
  localparam int unsigned CW = bsphd_pkg::MUL_CNT_W;

  logic [AW-1:0] a_r;
  logic [PW-1:0] p_r;
  logic [PW-1:0] p_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [AW:0]   sum;

  always_comb begin
    sum   = {1'b0, p_r[PW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
    p_nxt = {sum, p_r[BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(bsphd_pkg::MUL_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {{AW{1'b0}}, req.b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.prod = p_r;

endmodule

// ===== rtl/core/bsphd_ser_div.sv =====
// Restoring divider, one quotient bit per cycle, for num <= den.
module bsphd_ser_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsphd_pkg::div_req_t  req,
  output bsphd_pkg::div_rsp_t  rsp
);

  localparam int unsigned RW = bsphd_pkg::REG_W;
  localparam int unsigned QW = bsphd_pkg::DIV_Q_W;
  localparam int unsigned CW = bsphd_pkg::DIV_CNT_W;

  logic [RW-1:0] den_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [RW:0]   t;
  logic [RW:0]   diff;
  logic          ge;

  // first step takes the integer bit, later steps shift the remainder
  always_comb begin
    t       = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff    = t - {1'b0, den_r};
    ge      = (t >= {1'b0, den_r});
    rem_nxt = ge ? diff[RW-1:0] : t[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(bsphd_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      rem_r <= req.num;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = q_r;

endmodule

// ===== rtl/core/bemf_speed_pi_hbridge_drive.sv =====
// Top level: back-EMF speed estimate, PI speed loop and H-bridge duty/direction output.
// Input is accepted only in idle, so a new transaction waits until the previous result is loaded.
// Each transaction makes seven 31-step passes of the shared shift-add multiplier (six when the
// integrator holds) plus the 16-step restoring divide.
// Reset: rst_n synchronous active low; registers to defaults, duty and integrator to zero.
`include "bemf_speed_pi_hbridge_drive_macros.svh"

module bemf_speed_pi_hbridge_drive #(
  parameter int unsigned PWM_PERIOD        = bsphd_pkg::PWM_PERIOD_DEF,
  parameter int unsigned SAMPLE_FULL_SCALE = bsphd_pkg::SAMPLE_FULL_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bsphd_in_if.sink                        in_ch,
  bsphd_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [bsphd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsphd_pkg::REG_W-1:0]     cfg_wdata
);

  localparam int unsigned RW = bsphd_pkg::REG_W;
  localparam int unsigned SW = bsphd_pkg::SAMPLE_W;
  localparam int unsigned DW = bsphd_pkg::DUTY_W;
  localparam int unsigned PW = bsphd_pkg::MUL_P_W;
  localparam int unsigned QS = 16;

  localparam logic [bsphd_pkg::PARAM_W-1:0] PERIOD_V =
    PWM_PERIOD[bsphd_pkg::PARAM_W-1:0];
  localparam logic [bsphd_pkg::PARAM_W-1:0] SFS_V =
    SAMPLE_FULL_SCALE[bsphd_pkg::PARAM_W-1:0];

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat_q16(input logic [PW-1:0] p, input logic neg);
    logic [PW-QS-1:0] m;
    m = p[PW-1:QS];
    if (!neg) begin
      if (|m[PW-QS-1:31]) return S32_MAX;
      return {1'b0, m[30:0]};
    end
    if (|m[PW-QS-1:32] || (m[31] && |m[30:0])) return S32_MIN;
    return ~m[31:0] + 32'd1;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? S32_MIN : S32_MAX;
    return v[31:0];
  endfunction

  bsphd_pkg::cfg_t     cfg;
  bsphd_pkg::mul_req_t mul_req;
  bsphd_pkg::mul_rsp_t mul_rsp;
  bsphd_pkg::div_req_t div_req;
  bsphd_pkg::div_rsp_t div_rsp;

  bsphd_pkg::state_t state_r;
  bsphd_pkg::state_t state_nxt;

  logic [SW-1:0]        samp_r;
  logic signed [31:0]   target_r;
  logic [RW-1:0]        cur_r;
  logic signed [31:0]   volt_r;
  logic signed [31:0]   speed_r;
  logic signed [31:0]   err_r;
  logic signed [31:0]   prop_r;
  logic signed [31:0]   integ_r;
  logic [RW-1:0]        pmag_r;
  logic                 pneg_r;
  logic [DW-1:0]        dcm_r;
  logic                 dcneg_r;
  logic [DW-1:0]        dmag_r;
  logic                 dneg_r;
  logic [bsphd_pkg::PWM_W-1:0] pwm_r;
  logic signed [DW-1:0] duty_now_r;

  logic                 out_valid_r;
  logic [bsphd_pkg::PWM_W-1:0] o_pwm_r;
  logic [bsphd_pkg::DIR_W-1:0] o_dir_r;
  logic                 o_pause_r;
  logic signed [31:0]   o_speed_r;
  logic [RW-1:0]        o_cur_r;

  logic                 load_out;
  logic [SW-1:0]        samp_nxt;
  logic [RW-1:0]        cur_nxt;
  logic signed [48:0]   dw;
  logic signed [48:0]   dw24;
  logic signed [48:0]   ir49;
  logic signed [48:0]   vsum;
  logic signed [31:0]   volt_nxt;
  logic signed [31:0]   err_nxt;
  logic signed [31:0]   integ_nxt;
  logic signed [31:0]   mterm;
  logic signed [32:0]   pid;
  logic [32:0]          pidmag;
  logic [RW-1:0]        om;
  logic [RW-1:0]        pmag_nxt;
  logic                 target_pos;
  logic                 blocked;
  logic [PW-QS-1:0]     hmag;
  logic [DW-1:0]        dmag_nxt;
  logic [bsphd_pkg::DIR_W-1:0] dir_nxt;
  logic                 pause_nxt;
  logic signed [DW-1:0] duty_nxt;
  logic                 over_db;

  bsphd_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  bsphd_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  bsphd_ser_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // datapath arithmetic
  always_comb begin
    samp_nxt = ({4'b0, in_ch.filtered_sample} > SFS_V) ? SFS_V[SW-1:0]
                                                        : in_ch.filtered_sample;
    cur_nxt  = (|mul_rsp.prod[PW-1:RW]) ? {RW{1'b1}} : mul_rsp.prod[RW-1:0];

    dw       = 49'(duty_now_r);
    dw24     = (dw <<< 4) + (dw <<< 3);
    ir49     = {2'b00, mul_rsp.prod[PW-1:QS]};
    vsum     = duty_now_r[DW-1] ? (dw24 + ir49) : (dw24 - ir49);
    volt_nxt = (&vsum[48:31] || ~|vsum[48:31]) ? vsum[31:0]
                                               : (vsum[48] ? S32_MIN : S32_MAX);

    err_nxt   = sat33({target_r[31], target_r} - {speed_r[31], speed_r});
    over_db   = mag32(err_r) > {1'b0, cfg.error_deadband};
    mterm     = sat_q16(mul_rsp.prod, err_r[31]);
    integ_nxt = sat33({integ_r[31], integ_r} + {mterm[31], mterm});

    om       = (cfg.output_max == '0) ? RW'(1) : cfg.output_max;
    pid      = {prop_r[31], prop_r} + {integ_r[31], integ_r};
    pidmag   = pid[32] ? (~pid + 33'd1) : pid;
    pmag_nxt = (pidmag > {2'b00, om}) ? om : pidmag[RW-1:0];

    target_pos = !target_r[31] && (|target_r[30:0]);
    blocked    = (pneg_r && target_pos) || (!pneg_r && target_r[31]);

    hmag     = mul_rsp.prod[PW-1:QS];
    dmag_nxt = (hmag > (PW-QS)'(bsphd_pkg::DUTY_ONE)) ? bsphd_pkg::DUTY_ONE : hmag[DW-1:0];

    if (dmag_r == '0) begin
      dir_nxt   = bsphd_pkg::DIR_OFF;
      pause_nxt = 1'b0;
      duty_nxt  = '0;
    end else if (!dneg_r) begin
      dir_nxt   = bsphd_pkg::DIR_FWD;
      pause_nxt = duty_now_r[DW-1];
      duty_nxt  = dmag_r[DW-1] ? bsphd_pkg::DUTY_MAX : dmag_r;
    end else begin
      dir_nxt   = bsphd_pkg::DIR_REV;
      pause_nxt = !duty_now_r[DW-1];
      duty_nxt  = ~dmag_r + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    mul_req.start = state_r inside {bsphd_pkg::ST_CUR_GO, bsphd_pkg::ST_IR_GO,
                                    bsphd_pkg::ST_SPD_GO, bsphd_pkg::ST_INT_GO,
                                    bsphd_pkg::ST_PRP_GO, bsphd_pkg::ST_HLP_GO,
                                    bsphd_pkg::ST_PWM_GO};
    mul_req.a     = mag32(err_r);
    mul_req.b     = cfg.prop_gain;
    div_req.start = (state_r == bsphd_pkg::ST_DIV_GO);
    div_req.num   = pmag_r;
    div_req.den   = om;

    case (state_r)
      bsphd_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = bsphd_pkg::ST_CUR_GO;
      bsphd_pkg::ST_CUR_GO: begin
        mul_req.a = {20'b0, samp_r};
        mul_req.b = cfg.current_gain;
        state_nxt = bsphd_pkg::ST_CUR_WT;
      end
      bsphd_pkg::ST_CUR_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_IR_GO;
      bsphd_pkg::ST_IR_GO: begin
        mul_req.a = {1'b0, cur_r};
        mul_req.b = cfg.winding_resistance;
        state_nxt = bsphd_pkg::ST_IR_WT;
      end
      bsphd_pkg::ST_IR_WT:  if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_SPD_GO;
      bsphd_pkg::ST_SPD_GO: begin
        mul_req.a = mag32(volt_r);
        mul_req.b = cfg.speed_constant;
        state_nxt = bsphd_pkg::ST_SPD_WT;
      end
      bsphd_pkg::ST_SPD_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_ERR;
      bsphd_pkg::ST_ERR:    state_nxt = bsphd_pkg::ST_DBD;
      bsphd_pkg::ST_DBD:    state_nxt = over_db ? bsphd_pkg::ST_INT_GO : bsphd_pkg::ST_PRP_GO;
      bsphd_pkg::ST_INT_GO: begin
        mul_req.b = cfg.integ_step_gain;
        state_nxt = bsphd_pkg::ST_INT_WT;
      end
      bsphd_pkg::ST_INT_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_PRP_GO;
      bsphd_pkg::ST_PRP_GO: state_nxt = bsphd_pkg::ST_PRP_WT;
      bsphd_pkg::ST_PRP_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_LIM;
      bsphd_pkg::ST_LIM:    state_nxt = bsphd_pkg::ST_DIV_GO;
      bsphd_pkg::ST_DIV_GO: state_nxt = bsphd_pkg::ST_DIV_WT;
      bsphd_pkg::ST_DIV_WT: if (!div_rsp.busy) state_nxt = bsphd_pkg::ST_HLP_GO;
      bsphd_pkg::ST_HLP_GO: begin
        mul_req.a = {16'b0, dcm_r};
        mul_req.b = cfg.help_factor;
        state_nxt = bsphd_pkg::ST_HLP_WT;
      end
      bsphd_pkg::ST_HLP_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_PWM_GO;
      bsphd_pkg::ST_PWM_GO: begin
        mul_req.a = {16'b0, dmag_r};
        mul_req.b = {15'b0, PERIOD_V};
        state_nxt = bsphd_pkg::ST_PWM_WT;
      end
      bsphd_pkg::ST_PWM_WT: if (!mul_rsp.busy) state_nxt = bsphd_pkg::ST_DONE;
      bsphd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = bsphd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsphd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsphd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // loop state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      duty_now_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        duty_now_r  <= duty_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == bsphd_pkg::ST_INT_WT && !mul_rsp.busy) integ_r <= integ_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      bsphd_pkg::ST_IDLE: begin
        samp_r   <= samp_nxt;
        target_r <= in_ch.target_speed;
      end
      bsphd_pkg::ST_CUR_WT: if (!mul_rsp.busy) cur_r <= cur_nxt;
      bsphd_pkg::ST_IR_WT:  if (!mul_rsp.busy) volt_r <= volt_nxt;
      bsphd_pkg::ST_SPD_WT: if (!mul_rsp.busy) speed_r <= sat_q16(mul_rsp.prod, volt_r[31]);
      bsphd_pkg::ST_ERR:    err_r <= err_nxt;
      bsphd_pkg::ST_PRP_WT: if (!mul_rsp.busy) prop_r <= mterm;
      bsphd_pkg::ST_LIM: begin
        pmag_r <= pmag_nxt;
        pneg_r <= pid[32];
      end
      bsphd_pkg::ST_DIV_WT: begin
        if (!div_rsp.busy) begin
          dcm_r   <= blocked ? '0 : div_rsp.quot;
          dcneg_r <= pneg_r;
        end
      end
      bsphd_pkg::ST_HLP_WT: begin
        if (!mul_rsp.busy) begin
          dmag_r <= dmag_nxt;
          dneg_r <= dcneg_r;
        end
      end
      bsphd_pkg::ST_PWM_WT: if (!mul_rsp.busy) pwm_r <= mul_rsp.prod[30:15];
      bsphd_pkg::ST_DONE: begin
        if (load_out) begin
          o_pwm_r   <= pwm_r;
          o_dir_r   <= dir_nxt;
          o_pause_r <= pause_nxt;
          o_speed_r <= speed_r;
          o_cur_r   <= cur_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready            = (state_r == bsphd_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.pwm_compare     = o_pwm_r;
  assign out_ch.drive_direction = o_dir_r;
  assign out_ch.dead_time_pause = o_pause_r;
  assign out_ch.speed_estimate  = o_speed_r;
  assign out_ch.motor_current   = o_cur_r;

  `BSPHD_ASSERT(A_MUL_START_FREE, mul_req.start |-> !mul_rsp.busy, "multiplier restarted while busy")
  `BSPHD_ASSERT(A_IDLE_UNITS, in_ch.ready |-> (!mul_rsp.busy && !div_rsp.busy),
                "unit busy in idle")
  `BSPHD_ASSERT_NEXT(A_INTEG_HOLD, state_r != bsphd_pkg::ST_INT_WT, $stable(integ_r),
                     "integrator moved")
  `BSPHD_ASSERT(A_OFF_QUIET,
                (out_valid_r && o_dir_r == bsphd_pkg::DIR_OFF) |-> (o_pwm_r == '0 && !o_pause_r),
                "drive off with pwm or pause")

endmodule
